>>> hdl/iqm_pkg.sv
`default_nettype none

package iqm_pkg;

    // oscillator table
    localparam int TABLE_DEPTH = 4096;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = TBL_AW + 1;

    // configuration registers
    localparam int          TL_W     = 13;
    localparam logic [12:0] TL_RESET = 13'd4096;
    localparam int          APB_AW   = 3;

    localparam logic REG_TABLE_LENGTH = 1'b0;
    localparam logic REG_REVERSE_LO   = 1'b1;

    // command carried in tuser
    localparam logic CMD_MIX      = 1'b0;
    localparam logic CMD_TABLE_WR = 1'b1;

    // field layout of the input tdata
    localparam int ADDR_W    = 12;
    localparam int SMP_W     = 16;
    localparam int OFS_ADDR  = 0;
    localparam int OFS_SINE  = OFS_ADDR + ADDR_W;
    localparam int OFS_COS   = OFS_SINE + SMP_W;
    localparam int OFS_SI    = OFS_COS + SMP_W;
    localparam int OFS_SQ    = OFS_SI + SMP_W;
    localparam int IN_DATA_W = 80;

    localparam int OUT_DATA_W = 2 * SMP_W;
    localparam int FRAC_BITS  = 15;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [SMP_W-1:0] sine;
        logic signed [SMP_W-1:0] cosine;
        logic signed [SMP_W-1:0] si;
        logic signed [SMP_W-1:0] sq;
        logic                    last;
    } t_mix_item;

    typedef struct packed {
        logic        valid;
        t_mix_item   item;
    } t_push;

endpackage

`default_nettype wire

>>> hdl/iqm_ram.sv
`default_nettype none

module iqm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/iqm_front.sv
`default_nettype none

module iqm_front import iqm_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
    input  wire logic                 s_axis_tuser,
    input  wire logic                 s_axis_tlast,
    input  wire logic [TL_W-1:0]      i_len,
    input  wire logic [QCNT_W-1:0]    i_q_count,
    output t_push                     o_push
);

    logic                    acc;
    logic                    is_wr;
    logic [ADDR_W-1:0]       addr;
    logic                    addr_ok;
    logic [LEN_W-1:0]        len_eff;
    logic [TBL_AW-1:0]       idx;
    logic [LEN_W-1:0]        idx_inc;
    logic [TBL_AW-1:0]       nxt;
    logic [QCNT_W:0]         used;
    logic [2*SMP_W-1:0]      rdata;

    logic [TBL_AW-1:0]       r_phase;
    logic [TBL_AW-1:0]       n_phase;
    logic                    r_rd_valid;
    logic signed [SMP_W-1:0] r_si;
    logic signed [SMP_W-1:0] r_sq;
    logic                    r_last;

    assign used          = {1'b0, i_q_count} + {{QCNT_W{1'b0}}, r_rd_valid};
    assign s_axis_tready = used < (QCNT_W + 1)'(QUEUE_DEPTH);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign is_wr         = (s_axis_tuser == CMD_TABLE_WR);
    assign addr          = s_axis_tdata[OFS_ADDR +: ADDR_W];
    assign addr_ok       = 32'(addr) < 32'(TABLE_DEPTH);

    // zero or oversized length means the whole table
    always_comb begin
        if (i_len == '0 || 32'(i_len) > 32'(TABLE_DEPTH)) begin
            len_eff = LEN_W'(TABLE_DEPTH);
        end else begin
            len_eff = LEN_W'(i_len);
        end
    end

    assign idx     = ({1'b0, r_phase} >= len_eff) ? '0 : r_phase;
    assign idx_inc = {1'b0, idx} + LEN_W'(1);
    assign nxt     = (idx_inc >= len_eff) ? '0 : idx_inc[TBL_AW-1:0];

    always_comb begin
        n_phase = r_phase;
        if (acc) begin
            n_phase = is_wr ? '0 : nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_rd_valid <= acc && !is_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && !is_wr) begin
            r_si   <= s_axis_tdata[OFS_SI +: SMP_W];
            r_sq   <= s_axis_tdata[OFS_SQ +: SMP_W];
            r_last <= s_axis_tlast;
        end
    end

    // cosine in the upper half, sine in the lower half
    iqm_ram #(
        .WIDTH (2 * SMP_W),
        .DEPTH (TABLE_DEPTH)
    ) u_lo_ram (
        .i_clk   (i_clk),
        .i_we    (acc && is_wr && addr_ok),
        .i_waddr (TBL_AW'(addr)),
        .i_wdata ({s_axis_tdata[OFS_COS +: SMP_W], s_axis_tdata[OFS_SINE +: SMP_W]}),
        .i_re    (acc && !is_wr),
        .i_raddr (idx),
        .o_rdata (rdata)
    );

    assign o_push.valid       = r_rd_valid;
    assign o_push.item.sine   = rdata[SMP_W-1:0];
    assign o_push.item.cosine = rdata[2*SMP_W-1:SMP_W];
    assign o_push.item.si     = r_si;
    assign o_push.item.sq     = r_sq;
    assign o_push.item.last   = r_last;

    a_wr_clears_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && is_wr) |=> (r_phase == '0))
        else $error("phase index not cleared after table write");

endmodule

`default_nettype wire

>>> hdl/iqm_queue.sv
`default_nettype none

module iqm_queue import iqm_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_push              i_push,
    input  wire logic               i_pop,
    output logic                    o_valid,
    output t_mix_item               o_item,
    output logic [QCNT_W-1:0]       o_count
);

    t_mix_item         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= (32'(r_wr_ptr) == QUEUE_DEPTH - 1) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == QUEUE_DEPTH - 1) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push.valid) - QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> (r_count != QCNT_W'(QUEUE_DEPTH) || i_pop))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue underflow");

endmodule

`default_nettype wire

>>> hdl/iqm_back.sv
`default_nettype none

module iqm_back import iqm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_q_valid,
    input  wire t_mix_item             i_q_item,
    output logic                       o_q_pop,
    input  wire logic                  i_rev,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tlast
);

    localparam logic signed [32:0] SAT_MAX = 33'sh0_3FFF_FFFF;
    localparam logic signed [32:0] SAT_MIN = 33'sh1_C000_0000;

    function automatic logic [SMP_W-1:0] sat_shift(input logic signed [32:0] v);
        logic signed [32:0] c;
        if (v > SAT_MAX) begin
            c = SAT_MAX;
        end else if (v < SAT_MIN) begin
            c = SAT_MIN;
        end else begin
            c = v;
        end
        return c[FRAC_BITS+SMP_W-1:FRAC_BITS];
    endfunction

    logic                    out_move;
    logic                    s1_move;
    logic signed [SMP_W-1:0] lo_i;
    logic signed [SMP_W-1:0] lo_q;
    logic signed [32:0]      sum_i;
    logic signed [32:0]      sum_q;

    logic                    r_s1_valid;
    logic signed [31:0]      r_p_qi;
    logic signed [31:0]      r_p_iq;
    logic signed [31:0]      r_p_qq;
    logic signed [31:0]      r_p_ii;
    logic                    r_s1_last;
    logic                    r_out_valid;
    logic [SMP_W-1:0]        r_out_i;
    logic [SMP_W-1:0]        r_out_q;
    logic                    r_out_last;

    assign out_move = !r_out_valid || m_axis_tready;
    assign s1_move  = !r_s1_valid || out_move;
    assign o_q_pop  = i_q_valid && s1_move;

    assign lo_i = i_rev ? i_q_item.sine : i_q_item.cosine;
    assign lo_q = i_rev ? i_q_item.cosine : i_q_item.sine;

    assign sum_i = 33'(r_p_qi) + 33'(r_p_iq);
    assign sum_q = 33'(r_p_qq) - 33'(r_p_ii);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_move) begin
                r_s1_valid <= i_q_valid;
            end
            if (out_move) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_p_qi    <= i_q_item.sq * lo_i;
            r_p_iq    <= i_q_item.si * lo_q;
            r_p_qq    <= i_q_item.sq * lo_q;
            r_p_ii    <= i_q_item.si * lo_i;
            r_s1_last <= i_q_item.last;
        end
        if (out_move && r_s1_valid) begin
            r_out_i    <= sat_shift(sum_i);
            r_out_q    <= sat_shift(sum_q);
            r_out_last <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_q, r_out_i};
    assign m_axis_tlast  = r_out_last;

    a_pop_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_s1_valid)
        else $error("popped item lost before product stage");

endmodule

`default_nettype wire

>>> hdl/iq_complex_mixer.sv
// a mix transfer passes from the table read register through the queue and the product stage to the output register
// throughput: one item per cycle while the output is not stalled; table lookup, products and saturation are pipelined
// a table-write transfer produces no output
// the 4-entry queue between lookup and arithmetic absorbs output stalls
// reset (synchronous, active low): phase index 0, table_length 4096, reverse_lo 0;
// table contents are not cleared and must be loaded before mixing
`default_nettype none

module iq_complex_mixer import iqm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // apb configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_AW-1:0]     paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    // input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [11:0] table_addr, [27:12] table_sine, [43:28] table_cosine,
    // [59:44] sample_i, [75:60] sample_q, [79:76] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                  s_axis_tuser,  // [0] cmd
    input  wire logic                  s_axis_tlast,  // block_end
    // output stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // [15:0] mixed_i, [31:16] mixed_q
    output logic                       m_axis_tlast   // block_end_out
);

    logic [TL_W-1:0]   r_len;
    logic              r_rev;
    logic              cfg_wr;
    logic              reg_sel;

    t_push             push;
    logic              q_valid;
    t_mix_item         q_item;
    logic              q_pop;
    logic [QCNT_W-1:0] q_count;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= TL_RESET;
            r_rev <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_TABLE_LENGTH: r_len <= pwdata[TL_W-1:0];
                REG_REVERSE_LO:   r_rev <= pwdata[0];
                default:          r_rev <= r_rev;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_TABLE_LENGTH: prdata = 32'(r_len);
            REG_REVERSE_LO:   prdata = 32'(r_rev);
            default:          prdata = '0;
        endcase
    end

    iqm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .i_len         (r_len),
        .i_q_count     (q_count),
        .o_push        (push)
    );

    iqm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item),
        .o_count (q_count)
    );

    iqm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .i_rev         (r_rev),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire
